// ===== hdl/pr80_pkg.sv =====
// Shared types, constants and round functions for the PRESENT-80 cipher core.
// Depends on nothing; every other file in hdl imports it.
package pr80_pkg;

   localparam int BLOCK_W   = 64;
   localparam int KEY_W     = 80;
   localparam int KEY_LOW_W = 16;
   localparam int RK_NUM    = 32;
   localparam int RK_AW     = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [RK_AW-1:0] RK_LAST = RK_AW'(RK_NUM - 1);

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b1;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };
   localparam logic [3:0] SBOX_INV [16] = '{
      4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
      4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
   };

   typedef struct packed {
      logic load;   // take the cipher key from the key registers
      logic step;   // advance to the next round key
   } key_ctrl_type;

   typedef struct packed {
      logic load;       // take a new block
      logic round;      // apply one full round
      logic final_xor;  // apply only the closing key XOR
      logic decrypt;    // inverse round
   } dp_ctrl_type;

   function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] v,
                                                     input logic inv);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = inv ? SBOX_INV[v[4*n +: 4]] : SBOX_FWD[v[4*n +: 4]];
      end
      return r;
   endfunction

   // bit s moves to 16*(s mod 4) + s/4
   function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      logic [5:0]         s6;
      r = '0;
      for (int s = 0; s < BLOCK_W; s++) begin
         s6 = 6'(s);
         r[{s6[1:0], s6[5:2]}] = v[s6];
      end
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      logic [5:0]         s6;
      r = '0;
      for (int s = 0; s < BLOCK_W; s++) begin
         s6 = 6'(s);
         r[s6] = v[{s6[1:0], s6[5:2]}];
      end
      return r;
   endfunction

   // one key schedule step: rotate left by 61, S-box the top nibble,
   // mix the round counter into bits 19..15
   function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] k,
                                                 input logic [RK_AW-1:0] rc);
      logic [KEY_W-1:0] t;
      t = {k[18:0], k[79:19]};
      t[79:76] = SBOX_FWD[t[79:76]];
      t[19:15] = t[19:15] ^ rc;
      return t;
   endfunction

endpackage

// ===== hdl/present80_block_cipher_top.sv =====
// PRESENT-80 block cipher core: key registers, round key table fill, round control.
// Depends on pr80_pkg, pr80_key_ram, pr80_key_gen and pr80_datapath.
//
// Usage:
//  - Write the 80-bit key through the csr_ port: index CSR_KEY_HIGH takes key
//    bits 79..16, index CSR_KEY_LOW takes bits 15..0 from csr_wr_data[15:0].
//  - Any key write (and reset) starts a fill of the 32-entry round key memory:
//    one round key per cycle, restarted by a further key write. req_stall stays
//    high until the fill is done.
//  - Request beat: req_func (0 encrypt, 1 decrypt) and req_data_in, taken when
//    req_valid is high and req_stall low. Response beat: rsp_data_out, taken
//    when rsp_valid is high and rsp_stall low.
//  - The result and rsp_valid are registered after the request beat once 31 rounds
//    plus the closing key XOR are done, one round key read per cycle; the core
//    then passes through the idle state to take the next beat.
//  - One block is in the core at a time. A finished result waits in the output
//    register; if the previous result is still stalled there, the core holds
//    the new result until the response register frees up.
//  - Reset clears the key to zero, drops any block in flight and any pending
//    response, and runs the key table fill.
module present80_block_cipher_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [pr80_pkg::BLOCK_W-1:0]        req_data_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pr80_pkg::BLOCK_W-1:0]        rsp_data_out,
   input  logic                                csr_wr_en,
   input  logic [pr80_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pr80_pkg::BLOCK_W-1:0]        csr_wr_data
);
   import pr80_pkg::*;

   typedef enum logic [1:0] {
      ST_SWEEP,   // fill round key memory
      ST_IDLE,    // wait for a request beat
      ST_RUN,     // one round per cycle
      ST_FLUSH    // result done, response register still occupied
   } state_type;

   state_type           state_ff, state_in;
   logic [RK_AW-1:0]    cnt_ff, cnt_in;
   logic                func_ff, func_in;
   logic                dirty_ff, dirty_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [BLOCK_W-1:0]  key_high_ff, key_high_in;
   logic [KEY_LOW_W-1:0] key_low_ff, key_low_in;

   logic [RK_AW-1:0]    cnt_next;
   logic [RK_AW-1:0]    ram_rd_addr;
   logic                ram_we;
   logic [BLOCK_W-1:0]  ram_rd_data;
   logic [BLOCK_W-1:0]  gen_round_key;
   logic [BLOCK_W-1:0]  dp_state;
   logic [BLOCK_W-1:0]  dp_final;
   logic                rsp_free;
   logic                req_beat;
   key_ctrl_type        key_ctrl;
   dp_ctrl_type         dp_ctrl;

   // ---------------------------------------------------------------------
   // Key registers
   // ---------------------------------------------------------------------
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_wr_data;
            CSR_KEY_LOW:  key_low_in  = csr_wr_data[KEY_LOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   // Stall unless idle (filling the table, running or holding a block) or while a key write is pending.
   assign req_stall = (state_ff != ST_IDLE) || dirty_ff || csr_wr_en;
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_next  = RK_AW'(cnt_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      dirty_in     = dirty_ff || csr_wr_en;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      key_ctrl     = '0;
      dp_ctrl      = '0;
      dp_ctrl.decrypt = func_ff;
      ram_we       = 1'b0;
      // decrypt walks the table from the top: address 31 - i
      ram_rd_addr  = cnt_next ^ {RK_AW{func_ff}};

      case (state_ff)
         ST_SWEEP: begin
            if (dirty_ff) begin
               // restart the fill from the current key
               key_ctrl.load = 1'b1;
               cnt_in        = '0;
               dirty_in      = csr_wr_en;
            end else begin
               ram_we        = 1'b1;
               key_ctrl.step = 1'b1;
               cnt_in        = cnt_next;
               if (cnt_ff == RK_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            // prefetch the first round key of the incoming beat
            ram_rd_addr = {RK_AW{req_func}};
            if (dirty_ff) begin
               state_in = ST_SWEEP;
            end else if (req_beat) begin
               func_in      = req_func;
               dp_ctrl.load = 1'b1;
               cnt_in       = '0;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == RK_LAST) begin
               if (rsp_free) begin
                  rsp_data_in  = dp_final;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  dp_ctrl.final_xor = 1'b1;
                  state_in          = ST_FLUSH;
               end
            end else begin
               dp_ctrl.round = 1'b1;
               cnt_in        = cnt_next;
            end
         end
         ST_FLUSH: begin
            if (rsp_free) begin
               rsp_data_in  = dp_state;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cnt_ff       <= '0;
         func_ff      <= 1'b0;
         dirty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         func_ff      <= func_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   // Table writes happen only in the fill and reads are used only in a run,
   // so a read that lands on the entry being written is never used.
   pr80_key_gen u_key_gen (
      .clock     (clock),
      .ctrl      (key_ctrl),
      .key_high  (key_high_ff),
      .key_low   (key_low_ff),
      .round_cnt (cnt_next),
      .round_key (gen_round_key)
   );

   pr80_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff),
      .wr_data (gen_round_key),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pr80_datapath u_datapath (
      .clock     (clock),
      .ctrl      (dp_ctrl),
      .data_in   (req_data_in),
      .round_key (ram_rd_data),
      .state_out (dp_state),
      .final_out (dp_final)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_beat_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_RUN) && (cnt_ff == '0))
      else $error("request beat did not start a run at round zero");

   a_flush_needs_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> rsp_valid_ff)
      else $error("holding a result while the response register is empty");

   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == ST_RUN) || ($past(state_ff) == ST_FLUSH))
      else $error("response raised outside the end of a run");

endmodule

// ===== hdl/pr80_key_ram.sv =====
// Round key store: 32 x 64-bit synchronous memory, one write and one read port.
// Read data is registered. Depends on pr80_pkg.
module pr80_key_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [pr80_pkg::RK_AW-1:0]    wr_addr,
   input  logic [pr80_pkg::BLOCK_W-1:0]  wr_data,
   input  logic [pr80_pkg::RK_AW-1:0]    rd_addr,
   output logic [pr80_pkg::BLOCK_W-1:0]  rd_data
);
   import pr80_pkg::*;

   logic [BLOCK_W-1:0] key_mem_ff [RK_NUM];
   logic [BLOCK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pr80_key_gen.sv =====
// Key schedule register: holds the 80-bit working key and steps it once a cycle
// while the round key table is being filled. Depends on pr80_pkg.
module pr80_key_gen (
   input  logic                             clock,
   input  pr80_pkg::key_ctrl_type           ctrl,
   input  logic [pr80_pkg::BLOCK_W-1:0]     key_high,
   input  logic [pr80_pkg::KEY_LOW_W-1:0]   key_low,
   input  logic [pr80_pkg::RK_AW-1:0]       round_cnt,
   output logic [pr80_pkg::BLOCK_W-1:0]     round_key
);
   import pr80_pkg::*;

   logic [KEY_W-1:0] kw_ff;
   logic [KEY_W-1:0] kw_in;

   always_comb begin
      kw_in = kw_ff;
      if (ctrl.load) begin
         kw_in = {key_high, key_low};
      end else if (ctrl.step) begin
         kw_in = key_next(kw_ff, round_cnt);
      end
   end

   always_ff @(posedge clock) begin
      kw_ff <= kw_in;
   end

   // round key is the top 64 bits
   assign round_key = kw_ff[KEY_W-1 -: BLOCK_W];

endmodule

// ===== hdl/pr80_datapath.sv =====
// Cipher state register with one forward or inverse PRESENT round per cycle.
// Depends on pr80_pkg.
module pr80_datapath (
   input  logic                          clock,
   input  pr80_pkg::dp_ctrl_type         ctrl,
   input  logic [pr80_pkg::BLOCK_W-1:0]  data_in,
   input  logic [pr80_pkg::BLOCK_W-1:0]  round_key,
   output logic [pr80_pkg::BLOCK_W-1:0]  state_out,
   output logic [pr80_pkg::BLOCK_W-1:0]  final_out
);
   import pr80_pkg::*;

   logic [BLOCK_W-1:0] st_ff;
   logic [BLOCK_W-1:0] st_in;
   logic [BLOCK_W-1:0] mixed;

   assign mixed = st_ff ^ round_key;

   always_comb begin
      st_in = st_ff;
      if (ctrl.load) begin
         st_in = data_in;
      end else if (ctrl.round) begin
         st_in = ctrl.decrypt ? sub_layer(perm_inv(mixed), 1'b1)
                              : perm_fwd(sub_layer(mixed, 1'b0));
      end else if (ctrl.final_xor) begin
         st_in = mixed;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign state_out = st_ff;
   assign final_out = mixed;

endmodule
